// File: sv/pcrl_pkg.sv
// Shared sizes, types and reset constants for the per-client request limiter.
package pcrl_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 48;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int COUNT_BITS = 8;
  localparam int SLOT_BITS  = 4;

  localparam logic [COUNT_BITS-1:0] MAX_REQ_RESET = COUNT_BITS'(3);

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Outcome of one table lookup, handed from the table to the result register.
  typedef struct packed {
    logic admit;
    logic is_new;
    idx_t idx;
  } lookup_t;

endpackage

// File: sv/pcrl_table.sv
// Client table: parallel key match, limit check and round-robin insertion.
module pcrl_table (
  input  logic                clk,
  input  logic                rst,
  input  pcrl_pkg::key_t      key,
  input  logic                update,
  input  pcrl_pkg::count_t    max_requests,
  output pcrl_pkg::lookup_t   result
);

  pcrl_pkg::key_t   entry_key   [pcrl_pkg::ENTRIES];
  pcrl_pkg::count_t entry_count [pcrl_pkg::ENTRIES];
  logic [pcrl_pkg::ENTRIES-1:0] entry_valid;
  pcrl_pkg::idx_t   insert_pointer;
  pcrl_pkg::idx_t   insert_pointer_next;

  logic [pcrl_pkg::ENTRIES-1:0] match;
  logic                         hit;
  pcrl_pkg::idx_t               hit_idx;
  logic                         below_limit;

  always_comb begin
    for (int i = 0; i < pcrl_pkg::ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_key[i] == key);
    end
  end

  // Lowest matching slot wins; scan from the top so lower slots overwrite.
  always_comb begin
    hit_idx = '0;
    for (int i = pcrl_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = pcrl_pkg::IDX_BITS'(i);
      end
    end
    hit = |match;
  end

  assign below_limit = entry_count[hit_idx] < max_requests;

  always_comb begin
    if (insert_pointer == pcrl_pkg::IDX_BITS'(pcrl_pkg::ENTRIES - 1)) begin
      insert_pointer_next = '0;
    end else begin
      insert_pointer_next = insert_pointer + pcrl_pkg::IDX_BITS'(1);
    end
  end

  always_comb begin
    result.admit  = hit ? below_limit : 1'b1;
    result.is_new = !hit;
    result.idx    = hit ? hit_idx : insert_pointer;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid    <= '0;
      insert_pointer <= '0;
      for (int i = 0; i < pcrl_pkg::ENTRIES; i++) begin
        entry_count[i] <= '0;
      end
    end else if (update) begin
      if (hit) begin
        if (below_limit) begin
          entry_count[hit_idx] <= entry_count[hit_idx] + pcrl_pkg::COUNT_BITS'(1);
        end
      end else begin
        entry_count[insert_pointer] <= pcrl_pkg::COUNT_BITS'(1);
        entry_valid[insert_pointer] <= 1'b1;
        insert_pointer              <= insert_pointer_next;
      end
    end
  end

  // Keys carry no reset; a slot's key is only compared once its valid bit is set.
  always_ff @(posedge clk) begin
    if (update && !hit) begin
      entry_key[insert_pointer] <= key;
    end
  end

endmodule

// File: sv/per_client_request_limiter.sv
// Per-client request limiter top level: input register, table and result register.
//
// Each transaction on the input channel (in_valid/in_ready, client_key) is one
// request from the client named by the key. Exactly one result transaction
// follows on the output channel (out_valid/out_ready, admitted, was_new, slot).
// A known client is admitted while its count is below max_requests and denied
// afterward; an unknown client is inserted at the round-robin slot and admitted.
// The configuration channel (cfg_valid/cfg_ready, cfg_data) writes max_requests;
// it is always ready and is meant to be written while no request is in flight.
// The key of an accepted input transaction sits in the input register while the
// table lookup and update land in the result register, which holds the result
// until it is taken on the output channel.
// Throughput is one request per cycle while the receiver takes results, set by the
// parallel compare of all table slots against the registered key.
// When the receiver stalls, the result register holds, the input register fills,
// and in_ready drops until the result is taken.
// Reset clears all valid bits, counts and the insert pointer, sets max_requests
// to 3, and empties both registers; the block is ready in the next cycle.
module per_client_request_limiter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcrl_pkg::COUNT_BITS-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pcrl_pkg::KEY_BITS-1:0]    client_key,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             admitted,
  output logic                             was_new,
  output logic [pcrl_pkg::SLOT_BITS-1:0]   slot
);

  pcrl_pkg::count_t  max_requests;
  logic              stage_valid;
  pcrl_pkg::key_t    stage_key;
  logic              advance;
  pcrl_pkg::lookup_t lookup;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_requests <= pcrl_pkg::MAX_REQ_RESET;
    end else if (cfg_valid) begin
      max_requests <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_key <= client_key;
    end
  end

  pcrl_table u_table (
    .clk          (clk),
    .rst          (rst),
    .key          (stage_key),
    .update       (advance),
    .max_requests (max_requests),
    .result       (lookup)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      admitted <= lookup.admit;
      was_new  <= lookup.is_new;
      slot     <= pcrl_pkg::SLOT_BITS'(lookup.idx);
    end
  end

endmodule
